FILE: hw/rtl/cdq_pkg.sv
// Shared constants, codes and types of the circular deque.
package cdq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  localparam int CMD_W      = 3;
  localparam int ST_W       = 3;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = CFG_IDX_W'(1);

  localparam logic MODE_IN_RESTRICTED  = 1'b0;
  localparam logic MODE_OUT_RESTRICTED = 1'b1;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW    = 3'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_ALLOWED = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY       = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_READ
  } cdq_state_t;

endpackage

FILE: hw/rtl/cdq_ram.sv
// Single-port-write, single-port-read slot memory with registered read data.
module cdq_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/circular_deque.sv
// Circular deque: a push or any command that answers at once writes its result
// straight to the output register. A pop reads the element from a synchronous
// slot memory with registered read data, then hands it to the output register.
// A list walks the queue from front to rear: the walk issues one memory
// read per cycle and hands one result per cycle to the output register. Output
// stalls hold the walk. A command is taken only while the block is idle and the
// output register is free or being emptied. Writing the capacity register empties
// the queue; writing the mode register keeps the contents.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int DATA_W = DATA_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Commands.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VAL_W-1:0]      in_tdata,   // [31:0] push_value
  input  logic [CMD_W-1:0]      in_tuser,   // [2:0] command
  // Results.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [VAL_W-1:0]      out_tdata,  // [31:0] element
  output logic [ST_W-1:0]       out_tuser,  // [2:0] status
  output logic                  out_tlast,
  // Register writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

  cdq_state_t state_r, state_nxt;

  logic [CAP_W-1:0]  capacity_r, capacity_nxt;
  logic              mode_r, mode_nxt;
  logic [IW-1:0]     front_r, front_nxt;
  logic [IW-1:0]     rear_r, rear_nxt;
  logic              empty_r, empty_nxt;
  logic [IW-1:0]     walk_r, walk_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic              last_r, last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_elem_r, out_elem_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CAPW-1:0]   cap_ext;
  logic [CW-1:0]     eff_cap;
  logic              out_room, in_fire, cfg_fire, full, not_allowed;
  logic [63:0]       push_wide, rd_wide;
  logic [IW-1:0]     walk_next_idx, push_idx;

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i,
                                             input logic [CW-1:0] cap);
    logic [CW-1:0] ip1;
    ip1 = CW'(i) + CW'(1);
    return (ip1 >= cap) ? IW'(0) : ip1[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i,
                                             input logic [CW-1:0] cap);
    logic [CW-1:0] cm1;
    cm1 = cap - CW'(1);
    return (i == IW'(0) || CW'(i) >= cap) ? cm1[IW-1:0] : i - IW'(1);
  endfunction

  // Capacity of zero acts as one; anything above the store depth acts as the depth.
  always_comb begin
    cap_ext = CAPW'(capacity_r);
    if (cap_ext == CAPW'(0)) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CAPW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_ext[CW-1:0];
    end
  end

  assign out_room  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_room;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign full = !empty_r && (idx_next(rear_r, eff_cap) == front_r);

  assign not_allowed = !(in_tuser inside {CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_POP_FRONT,
                                          CMD_POP_BACK, CMD_LIST})
                    || (in_tuser == CMD_PUSH_FRONT && mode_r == MODE_IN_RESTRICTED)
                    || (in_tuser == CMD_POP_FRONT && mode_r == MODE_OUT_RESTRICTED);

  assign push_wide     = 64'(in_tdata);
  assign rd_wide       = 64'(ram_rdata);
  assign walk_next_idx = idx_next(walk_r, eff_cap);

  always_comb begin
    if (empty_r) begin
      push_idx = (in_tuser == CMD_PUSH_FRONT) ? IW'(eff_cap - CW'(1)) : IW'(0);
    end else if (in_tuser == CMD_PUSH_FRONT) begin
      push_idx = idx_prev(front_r, eff_cap);
    end else begin
      push_idx = idx_next(rear_r, eff_cap);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && !not_allowed && !empty_r &&
            (in_tuser == CMD_POP_FRONT || in_tuser == CMD_POP_BACK ||
             in_tuser == CMD_LIST)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (out_room && last_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory accesses and results.
  always_comb begin
    capacity_nxt   = capacity_r;
    mode_nxt       = mode_r;
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    empty_nxt      = empty_r;
    walk_nxt       = walk_r;
    pos_nxt        = pos_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = push_idx;
    ram_wdata      = push_wide[DATA_W-1:0];
    ram_re         = 1'b0;
    ram_raddr      = front_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_elem_nxt = '0;
          out_last_nxt = 1'b1;
          if (not_allowed) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOT_ALLOWED;
          end else begin
            case (in_tuser)
              CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                out_valid_nxt = 1'b1;
                if (full) begin
                  out_status_nxt = ST_OVERFLOW;
                end else begin
                  out_status_nxt = ST_OK;
                  ram_we         = 1'b1;
                  empty_nxt      = 1'b0;
                  if (empty_r) begin
                    front_nxt = push_idx;
                    rear_nxt  = push_idx;
                  end else if (in_tuser == CMD_PUSH_FRONT) begin
                    front_nxt = push_idx;
                  end else begin
                    rear_nxt = push_idx;
                  end
                end
              end
              CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty_r) begin
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = ST_UNDERFLOW;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = (in_tuser == CMD_POP_FRONT) ? front_r : rear_r;
                  pos_nxt   = CW'(1);
                  last_nxt  = 1'b1;
                  if (front_r == rear_r) begin
                    front_nxt = '0;
                    rear_nxt  = '0;
                    empty_nxt = 1'b1;
                  end else if (in_tuser == CMD_POP_FRONT) begin
                    front_nxt = idx_next(front_r, eff_cap);
                  end else begin
                    rear_nxt = idx_prev(rear_r, eff_cap);
                  end
                end
              end
              default: begin
                if (empty_r) begin
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = ST_EMPTY;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = front_r;
                  walk_nxt  = front_r;
                  pos_nxt   = CW'(1);
                  last_nxt  = (front_r == rear_r) || (eff_cap <= CW'(1));
                end
              end
            endcase
          end
        end
      end
      S_READ: begin
        if (out_room) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_elem_nxt   = rd_wide[VAL_W-1:0];
          out_last_nxt   = last_r;
          if (!last_r) begin
            // The next element of the walk is read while this one is handed over.
            ram_re    = 1'b1;
            ram_raddr = walk_next_idx;
            walk_nxt  = walk_next_idx;
            pos_nxt   = pos_r + CW'(1);
            last_nxt  = (walk_next_idx == rear_r) || (pos_r + CW'(1) >= eff_cap);
          end
        end
      end
      default: ;
    endcase

    if (cfg_fire) begin
      if (cfg_index == CFG_CAPACITY) begin
        capacity_nxt = cfg_data[CAP_W-1:0];
        front_nxt    = '0;
        rear_nxt     = '0;
        empty_nxt    = 1'b1;
      end else if (cfg_index == CFG_MODE) begin
        mode_nxt = cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      capacity_r  <= CAP_RESET;
      mode_r      <= MODE_IN_RESTRICTED;
      front_r     <= '0;
      rear_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capacity_r  <= capacity_nxt;
      mode_r      <= mode_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r       <= walk_nxt;
    pos_r        <= pos_nxt;
    last_r       <= last_nxt;
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_last_r   <= out_last_nxt;
  end

  cdq_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_elem_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // An empty queue always has both indices parked at slot zero.
  a_empty_parked: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (front_r == '0) && (rear_r == '0))
    else $error("empty queue with indices away from zero");

  // Occupied indices stay inside the capacity in use.
  a_idx_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> (CW'(front_r) < eff_cap) && (CW'(rear_r) < eff_cap))
    else $error("queue index outside capacity");

  // A list walk never runs past the capacity in use.
  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (pos_r <= eff_cap))
    else $error("list walk beyond capacity");

endmodule
